// ----- design/c2es_pkg.sv -----
package c2es_pkg;

   // field widths
   localparam int YEAR_W    = 16;
   localparam int MONTH_W   = 8;
   localparam int DAY_W     = 8;
   localparam int HOUR_W    = 8;
   localparam int MINUTE_W  = 8;
   localparam int SECOND_W  = 8;
   localparam int SECS_W    = 32;
   localparam int MINS_W    = 26;

   // calendar constants
   localparam int YEAR_MODULUS  = 100;
   localparam int DAYS_PER_YEAR = 365;
   localparam int HOURS_PER_DAY = 24;
   localparam int MINS_PER_HOUR = 60;
   localparam int SECS_PER_MIN  = 60;
   localparam int MINS_PER_DAY  = HOURS_PER_DAY * MINS_PER_HOUR;
   localparam logic [1:0] LEAP_MASK = 2'h3;

   // year / 100 as (year * RECIP) >> RECIP_SHIFT, exact for every 16-bit year
   localparam int RECIP_SHIFT = 23;
   localparam logic [16:0] RECIP = 17'd83887;

   // largest count for the checks in the pipeline
   localparam logic [SECS_W-1:0] MAX_SECONDS = 32'd3155759999;

   // days in month m (1..12); codes outside that range never reach a valid result
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      begin
         unique case (m)
            4'd2: len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default: len = 5'd31;
         endcase
         return len;
      end
   endfunction

   // days in the months before month m of the year
   function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
      logic [8:0] d;
      begin
         unique case (m)
            4'd1: d = 9'd0;
            4'd2: d = 9'd31;
            4'd3: d = 9'd59;
            4'd4: d = 9'd90;
            4'd5: d = 9'd120;
            4'd6: d = 9'd151;
            4'd7: d = 9'd181;
            4'd8: d = 9'd212;
            4'd9: d = 9'd243;
            4'd10: d = 9'd273;
            4'd11: d = 9'd304;
            4'd12: d = 9'd334;
            default: d = 9'd0;
         endcase
         if (leap && m > 4'd2) begin
            d = d + 9'd1;
         end
         return d;
      end
   endfunction

endpackage

// ----- design/c2es_req_if.sv -----
interface c2es_req_if;
   logic                            valid;
   logic                            ready;
   logic [c2es_pkg::YEAR_W-1:0]     year;
   logic [c2es_pkg::MONTH_W-1:0]    month;
   logic [c2es_pkg::DAY_W-1:0]      day;
   logic [c2es_pkg::HOUR_W-1:0]     hour;
   logic [c2es_pkg::MINUTE_W-1:0]   minute;
   logic [c2es_pkg::SECOND_W-1:0]   second;

   modport source (output valid, year, month, day, hour, minute, second, input ready);
   modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

// ----- design/c2es_rsp_if.sv -----
interface c2es_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          time_valid;
   logic [c2es_pkg::SECS_W-1:0]   epoch_seconds;
   logic [c2es_pkg::MINS_W-1:0]   epoch_minutes;

   modport source (output valid, time_valid, epoch_seconds, epoch_minutes, input ready);
   modport sink   (input valid, time_valid, epoch_seconds, epoch_minutes, output ready);
endinterface

// ----- design/calendar_to_epoch_seconds.sv -----
// channel   direction  payload
// req_ch    in         year, month, day, hour, minute, second
// rsp_ch    out        time_valid, epoch_seconds, epoch_minutes
//
// Five register stages: year/100 by reciprocal multiply, year mod 100 and day
// check, day count, minute count, second count into the output register.
// One item per cycle while rsp_ch is not stalled; each item leaves through the output register.
// Synchronous reset clears the stage valid bits only.
// A stall on rsp_ch freezes all stages together; req_ch.ready follows it.
module calendar_to_epoch_seconds (
   input  logic               clock,
   input  logic               reset,
   c2es_req_if.sink           req_ch,
   c2es_rsp_if.source         rsp_ch
);

   logic       adv;
   logic [4:0] vld_ff, vld_in;

   // stage 1
   logic [15:0] year1_ff;
   logic [9:0]  cent1_ff, cent1_in;
   logic [32:0] cent_prod;
   logic        ok1_ff, ok1_in;
   logic [3:0]  month1_ff;
   logic [4:0]  day1_ff;
   logic [4:0]  hour1_ff;
   logic [5:0]  min1_ff;
   logic [5:0]  sec1_ff;

   // stage 2
   logic [15:0] yrem;
   logic [6:0]  yy2_ff, yy2_in;
   logic        leap2_ff, leap2_in;
   logic        ok2_ff, ok2_in;
   logic [3:0]  month2_ff;
   logic [4:0]  day2_ff;
   logic [4:0]  hour2_ff;
   logic [5:0]  min2_ff;
   logic [5:0]  sec2_ff;

   // stage 3
   logic [15:0] days3_ff, days3_in;
   logic        ok3_ff;
   logic [4:0]  hour3_ff;
   logic [5:0]  min3_ff;
   logic [5:0]  sec3_ff;

   // stage 4
   logic [25:0] mins4_ff, mins4_in;
   logic        ok4_ff;
   logic [5:0]  sec4_ff;

   // stage 5 (output)
   logic        ok5_ff;
   logic [31:0] secs5_ff, secs5_in;
   logic [25:0] mins5_ff, mins5_in;

   // advance the whole pipe unless the output item is waiting
   assign adv          = !vld_ff[4] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[3:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: century quotient and range checks that need no year
   always_comb begin
      cent_prod = {17'd0, req_ch.year} * {16'd0, c2es_pkg::RECIP};
      cent1_in  = cent_prod[c2es_pkg::RECIP_SHIFT +: 10];
      ok1_in    = (req_ch.month >= 8'd1) && (req_ch.month <= 8'd12)
               && (req_ch.day >= 8'd1) && (req_ch.day <= 8'd31)
               && (req_ch.hour <= 8'd23) && (req_ch.minute <= 8'd59)
               && (req_ch.second <= 8'd59);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         year1_ff  <= req_ch.year;
         cent1_ff  <= cent1_in;
         ok1_ff    <= ok1_in;
         month1_ff <= req_ch.month[3:0];
         day1_ff   <= req_ch.day[4:0];
         hour1_ff  <= req_ch.hour[4:0];
         min1_ff   <= req_ch.minute[5:0];
         sec1_ff   <= req_ch.second[5:0];
      end
   end

   // stage 2: year mod 100, leap flag, day against month length
   always_comb begin
      yrem     = year1_ff - 16'({6'd0, cent1_ff} * 16'(c2es_pkg::YEAR_MODULUS));
      yy2_in   = yrem[6:0];
      leap2_in = (yrem[1:0] & c2es_pkg::LEAP_MASK) == 2'd0;
      ok2_in   = ok1_ff && (day1_ff <= c2es_pkg::month_len(month1_ff, leap2_in));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yy2_ff    <= yy2_in;
         leap2_ff  <= leap2_in;
         ok2_ff    <= ok2_in;
         month2_ff <= month1_ff;
         day2_ff   <= day1_ff;
         hour2_ff  <= hour1_ff;
         min2_ff   <= min1_ff;
         sec2_ff   <= sec1_ff;
      end
   end

   // stage 3: days since the epoch; leap years before yy number (yy + 3) / 4
   always_comb begin
      days3_in = 16'({9'd0, yy2_ff} * 16'(c2es_pkg::DAYS_PER_YEAR))
               + 16'((yy2_ff + 7'd3) >> 2)
               + {7'd0, c2es_pkg::days_before(month2_ff, leap2_ff)}
               + {11'd0, day2_ff} - 16'd1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         days3_ff <= days3_in;
         ok3_ff   <= ok2_ff;
         hour3_ff <= hour2_ff;
         min3_ff  <= min2_ff;
         sec3_ff  <= sec2_ff;
      end
   end

   // stage 4: whole minutes
   always_comb begin
      mins4_in = 26'({10'd0, days3_ff} * 26'(c2es_pkg::MINS_PER_DAY))
               + 26'({21'd0, hour3_ff} * 26'(c2es_pkg::MINS_PER_HOUR))
               + {20'd0, min3_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mins4_ff <= mins4_in;
         ok4_ff   <= ok3_ff;
         sec4_ff  <= sec3_ff;
      end
   end

   // stage 5: seconds; zero both counts for a rejected time
   always_comb begin
      if (ok4_ff) begin
         secs5_in = 32'({6'd0, mins4_ff} * 32'(c2es_pkg::SECS_PER_MIN)) + {26'd0, sec4_ff};
         mins5_in = mins4_ff;
      end else begin
         secs5_in = '0;
         mins5_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok5_ff   <= ok4_ff;
         secs5_ff <= secs5_in;
         mins5_ff <= mins5_in;
      end
   end

   assign rsp_ch.valid         = vld_ff[4];
   assign rsp_ch.time_valid    = ok5_ff;
   assign rsp_ch.epoch_seconds = secs5_ff;
   assign rsp_ch.epoch_minutes = mins5_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.time_valid) |->
         (rsp_ch.epoch_seconds == '0 && rsp_ch.epoch_minutes == '0))
      else $error("rejected time with nonzero count");

   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.time_valid) |->
         (rsp_ch.epoch_seconds <= c2es_pkg::MAX_SECONDS))
      else $error("epoch seconds beyond the last day of the century");

   a_min_sec: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.time_valid) |->
         ((rsp_ch.epoch_seconds - 32'({6'd0, rsp_ch.epoch_minutes} * 32'd60)) < 32'd60))
      else $error("minute count disagrees with second count");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipe valid bits moved during a stall");

endmodule
